@@ hw/rtl/stqs_pkg.sv @@
package stqs_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam logic [7:0] IdInvalid = 8'd0;
  localparam logic [7:0] IdFirst = 8'd1;

  typedef enum logic [1:0] {
    ActSubmit = 2'd0,
    ActByteDone = 2'd1,
    ActQuery = 2'd2,
    ActClear = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SendNone = 2'd0,
    SendByte = 2'd1,
    SendDummy = 2'd2
  } send_e;

  typedef enum logic [1:0] {
    CsNone = 2'd0,
    CsAssert = 2'd1,
    CsRelease = 2'd2
  } cs_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StExec,
    StStartScan,
    StOut1,
    StOut2
  } state_e;

  typedef struct packed {
    logic       status;
    logic [7:0] reply_id;
    logic       done_answer;
    logic       recv_valid;
    logic [7:0] recv_index;
    logic [7:0] recv_byte;
    send_e      send_kind;
    logic [7:0] send_index;
    logic [7:0] bus_id;
    cs_e        cs_action;
    logic [2:0] chip_pin;
    logic       last;
  } result_t;

endpackage

@@ hw/rtl/stqs_out_reg.sv @@
module stqs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  stqs_pkg::result_t res_i,
  input  logic              stall_i,
  output logic              valid_o,
  output logic              busy_o,
  output stqs_pkg::result_t res_o
);
  import stqs_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d = res_q;
    if (valid_q && !stall_i) valid_d = 1'b0;
    if (load_i) begin
      valid_d = 1'b1;
      res_d = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign busy_o = valid_q && stall_i;
  assign res_o = res_q;
endmodule

@@ hw/rtl/spi_transaction_queue_sequencer_top.sv @@
// Request path: byte_done goes to exec, then out; a finish first scans for the next slot
// to start, and a second result follows the release when a slot starts. Query and clear
// scan the slots for the id; submit scans for a free slot, then for a slot to start.
// Throughput: one request at a time; the next can be taken in the cycle after the last
// result is loaded into the output register, later when the output stalls.
// Reset (rst_ni low, async): all slots free, head at slot 0, next id 1, no result pending.
module spi_transaction_queue_sequencer_top #(
  parameter int unsigned SLOTS = stqs_pkg::SlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic       fdx_i,
  input  logic [2:0] cs_pin_i,
  input  logic [2:0] attn_pin_i,
  input  logic [7:0] tx_len_i,
  input  logic [7:0] rx_len_i,
  input  logic [7:0] txn_id_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] port_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  output logic [7:0] reply_id_o,
  output logic       done_answer_o,
  output logic       recv_valid_o,
  output logic [7:0] recv_index_o,
  output logic [7:0] recv_byte_o,
  output logic [1:0] send_kind_o,
  output logic [7:0] send_index_o,
  output logic [7:0] bus_id_o,
  output logic [1:0] cs_action_o,
  output logic [2:0] chip_pin_o,
  output logic       last_o
);
  import stqs_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LastSlot = SW'(SLOTS - 1);
  localparam logic [CW-1:0] NumSlots = CW'(SLOTS);

  // slot storage; flags: fd, last attn, active, tx done, done
  logic [7:0]  id_q    [SLOTS];
  logic        fd_q    [SLOTS];
  logic        lattn_q [SLOTS];
  logic        act_q   [SLOTS];
  logic        dout_q  [SLOTS];
  logic        done_q  [SLOTS];
  logic [2:0]  cs_q    [SLOTS];
  logic [2:0]  at_q    [SLOTS];
  logic [7:0]  ol_q    [SLOTS];
  logic [7:0]  il_q    [SLOTS];
  logic [7:0]  bo_q    [SLOTS];
  logic [7:0]  bi_q    [SLOTS];

  state_e        st_q, st_d;
  logic [SW-1:0] head_q, idx_q;
  logic [CW-1:0] cnt_q;
  logic          found_q;
  logic [SW-1:0] hit_q;
  logic [7:0]    next_q;
  // latched request
  logic [1:0]    rq_act_q;
  logic          rq_fd_q;
  logic [2:0]    rq_cs_q, rq_at_q;
  logic [7:0]    rq_txl_q, rq_rxl_q, rq_id_q, rq_rx_q, rq_port_q;
  result_t       r1_q, r2_q;
  result_t       r1_d, r2_d;
  logic          two_q;

  logic          out_load, out_busy;
  result_t       out_res;
  logic          accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);

  logic [SW-1:0] idx_inc;
  assign idx_inc = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;

  // shared compare: one slot per cycle
  logic match;
  always_comb begin
    match = 1'b0;
    case (st_q)
      StScan: begin
        if (rq_act_q == ActSubmit) match = (id_q[idx_q] == IdInvalid);
        else match = (id_q[idx_q] == rq_id_q);
      end
      StStartScan: match = (id_q[idx_q] != IdInvalid) && !act_q[idx_q] && !done_q[idx_q];
      default: match = 1'b0;
    endcase
  end

  // byte_done datapath on head slot
  logic          h_attn, h_recv, h_more, h_dummy, h_fin;
  logic [7:0]    bi_n, bo_n;
  always_comb begin
    h_attn = rq_port_q[at_q[head_q]];
    h_recv = (!fd_q[head_q] && dout_q[head_q] && (bi_q[head_q] < il_q[head_q])) ||
             (fd_q[head_q] && (lattn_q[head_q] || h_attn));
    bi_n = h_recv ? bi_q[head_q] + 8'd1 : bi_q[head_q];
    bo_n = bo_q[head_q];
    h_more = bo_q[head_q] < ol_q[head_q];
    h_dummy = !h_more && ((fd_q[head_q] && h_attn) ||
                          (!fd_q[head_q] && bi_n < il_q[head_q]));
    h_fin = act_q[head_q] && !h_more && !h_dummy;
  end

  // start scan hit that actually starts a slot (bus idle at the head)
  logic start_hit;
  assign start_hit = (st_q == StStartScan) && match &&
                     !(act_q[head_q] && rq_act_q != ActByteDone);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (accept) st_d = (action_i == ActByteDone) ? StExec : StScan;
      StScan: if (match || cnt_q == NumSlots - 1'b1) st_d = StExec;
      StExec: begin
        // a submit that took a slot, or a finish, looks for the next slot to start
        if ((rq_act_q == ActSubmit && found_q) || (rq_act_q == ActByteDone && h_fin)) begin
          st_d = StStartScan;
        end else begin
          st_d = StOut1;
        end
      end
      StStartScan: if (match || cnt_q == NumSlots - 1'b1) st_d = StOut1;
      StOut1: if (!out_busy) st_d = two_q ? StOut2 : StIdle;
      StOut2: if (!out_busy) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      head_q <= '0;
      next_q <= IdFirst;
      for (int i = 0; i < SLOTS; i++) begin
        id_q[i] <= IdInvalid;
        fd_q[i] <= 1'b0;
        lattn_q[i] <= 1'b0;
        act_q[i] <= 1'b0;
        dout_q[i] <= 1'b0;
        done_q[i] <= 1'b0;
      end
      idx_q <= '0;
      cnt_q <= '0;
      found_q <= 1'b0;
      hit_q <= '0;
      two_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle: begin
          if (accept) begin
            two_q <= 1'b0;
            found_q <= 1'b0;
            cnt_q <= '0;
            idx_q <= (action_i == ActSubmit) ? head_q : '0;
          end
        end
        StScan: begin
          if (match) begin
            found_q <= 1'b1;
            hit_q <= idx_q;
          end else begin
            idx_q <= idx_inc;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StExec: begin
          cnt_q <= '0;
          case (action_e'(rq_act_q))
            ActSubmit: begin
              if (found_q) begin
                id_q[hit_q] <= next_q;
                next_q <= (next_q == 8'hFF) ? IdFirst : next_q + 8'd1;
                fd_q[hit_q] <= rq_fd_q;
                lattn_q[hit_q] <= 1'b0;
                act_q[hit_q] <= 1'b0;
                dout_q[hit_q] <= 1'b0;
                done_q[hit_q] <= 1'b0;
                cs_q[hit_q] <= rq_cs_q;
                at_q[hit_q] <= rq_fd_q ? rq_at_q : 3'd0;
                ol_q[hit_q] <= rq_txl_q;
                il_q[hit_q] <= rq_fd_q ? 8'd0 : rq_rxl_q;
                bo_q[hit_q] <= '0;
                bi_q[hit_q] <= '0;
                idx_q <= head_q;
              end
            end
            ActByteDone: begin
              if (act_q[head_q]) begin
                lattn_q[head_q] <= h_attn;
                bi_q[head_q] <= bi_n;
                if (h_more) bo_q[head_q] <= bo_n + 8'd1;
                else if (h_dummy) dout_q[head_q] <= 1'b1;
                else begin
                  done_q[head_q] <= 1'b1;
                  act_q[head_q] <= 1'b0;
                  head_q <= (head_q == LastSlot) ? '0 : head_q + 1'b1;
                  idx_q <= (head_q == LastSlot) ? '0 : head_q + 1'b1;
                  found_q <= 1'b1;
                end
              end
            end
            ActQuery: ;
            ActClear: if (found_q && !act_q[hit_q]) id_q[hit_q] <= IdInvalid;
            default: ;
          endcase
        end
        StStartScan: begin
          if (act_q[head_q] && !(rq_act_q == ActByteDone)) begin
            cnt_q <= NumSlots - 1'b1;
          end else if (match) begin
            head_q <= idx_q;
            act_q[idx_q] <= 1'b1;
            two_q <= (rq_act_q == ActByteDone);
            if (ol_q[idx_q] != 8'd0) bo_q[idx_q] <= 8'd1;
          end else begin
            idx_q <= idx_inc;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rq_act_q <= action_i;
      rq_fd_q <= fdx_i;
      rq_cs_q <= cs_pin_i;
      rq_at_q <= attn_pin_i;
      rq_txl_q <= tx_len_i;
      rq_rxl_q <= rx_len_i;
      rq_id_q <= txn_id_i;
      rq_rx_q <= rx_byte_i;
      rq_port_q <= port_level_i;
    end
  end

  // result assembly
  always_comb begin
    r1_d = r1_q;
    r2_d = r2_q;
    if (st_q == StExec) begin
      r1_d = '0;
      r1_d.last = 1'b1;
      case (action_e'(rq_act_q))
        ActSubmit: begin
          r1_d.status = !found_q;
          r1_d.reply_id = found_q ? next_q : 8'd0;
        end
        ActByteDone: begin
          if (act_q[head_q]) begin
            r1_d.bus_id = id_q[head_q];
            if (h_recv) begin
              r1_d.recv_valid = 1'b1;
              r1_d.recv_index = bi_q[head_q];
              r1_d.recv_byte = rq_rx_q;
            end
            if (h_more) begin
              r1_d.send_kind = SendByte;
              r1_d.send_index = bo_q[head_q];
            end else if (h_dummy) begin
              r1_d.send_kind = SendDummy;
            end else begin
              r1_d.cs_action = CsRelease;
              r1_d.chip_pin = cs_q[head_q];
            end
          end
        end
        ActQuery: r1_d.done_answer = found_q && done_q[hit_q];
        ActClear: r1_d.status = !(found_q && !act_q[hit_q]);
        default: ;
      endcase
    end
    if (start_hit) begin
      if (rq_act_q == ActByteDone) begin
        // release stays first, the start follows as a second result
        r1_d.last = 1'b0;
        r2_d = '0;
        r2_d.last = 1'b1;
        r2_d.cs_action = CsAssert;
        r2_d.chip_pin = cs_q[idx_q];
        r2_d.bus_id = id_q[idx_q];
        r2_d.send_kind = (ol_q[idx_q] != 8'd0) ? SendByte : SendDummy;
      end else begin
        r1_d.cs_action = CsAssert;
        r1_d.chip_pin = cs_q[idx_q];
        r1_d.bus_id = id_q[idx_q];
        r1_d.send_kind = (ol_q[idx_q] != 8'd0) ? SendByte : SendDummy;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= r1_d;
    r2_q <= r2_d;
  end

  // results leave through one output register, the second one after the first
  assign out_load = !out_busy && ((st_q == StOut1) || (st_q == StOut2));
  assign out_res = (st_q == StOut2) ? r2_q : r1_q;

  stqs_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (out_res),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .busy_o (out_busy),
    .res_o  ({status_o, reply_id_o, done_answer_o, recv_valid_o, recv_index_o,
              recv_byte_o, send_kind_o, send_index_o, bus_id_o, cs_action_o,
              chip_pin_o, last_o})
  );
endmodule

@@ bench/spi_transaction_queue_sequencer_top_test.sv @@
module spi_transaction_queue_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stqs_pkg::*;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned TailCycles = 4 * NumSlots + 20;
  localparam int unsigned HoldLen = 400;

  // one request as the driver sees it
  typedef struct packed {
    action_e    action;
    logic       fdx;
    logic [2:0] cs_pin;
    logic [2:0] attn_pin;
    logic [7:0] tx_len;
    logic [7:0] rx_len;
    logic [7:0] txn_id;
    logic [7:0] rx_byte;
    logic [7:0] port_level;
  } request_t;

  // result as seen on the ports
  typedef struct packed {
    logic       status;
    logic [7:0] reply_id;
    logic       done_answer;
    logic       recv_valid;
    logic [7:0] recv_index;
    logic [7:0] recv_byte;
    logic [1:0] send_kind;
    logic [7:0] send_index;
    logic [7:0] bus_id;
    logic [1:0] cs_action;
    logic [2:0] chip_pin;
    logic       last;
  } observed_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i;
  request_t req_q;
  observed_t got;

  spi_transaction_queue_sequencer_top #(.SLOTS(NumSlots)) u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i      (req_q.action),
    .fdx_i         (req_q.fdx),
    .cs_pin_i      (req_q.cs_pin),
    .attn_pin_i    (req_q.attn_pin),
    .tx_len_i      (req_q.tx_len),
    .rx_len_i      (req_q.rx_len),
    .txn_id_i      (req_q.txn_id),
    .rx_byte_i     (req_q.rx_byte),
    .port_level_i  (req_q.port_level),
    .out_valid_o,
    .out_stall_i,
    .status_o      (got.status),
    .reply_id_o    (got.reply_id),
    .done_answer_o (got.done_answer),
    .recv_valid_o  (got.recv_valid),
    .recv_index_o  (got.recv_index),
    .recv_byte_o   (got.recv_byte),
    .send_kind_o   (got.send_kind),
    .send_index_o  (got.send_index),
    .bus_id_o      (got.bus_id),
    .cs_action_o   (got.cs_action),
    .chip_pin_o    (got.chip_pin),
    .last_o        (got.last)
  );

  // Shadow of the sequencer state. Flags: full duplex, last attention level,
  // active, tx done, done.
  logic [7:0] sh_id     [NumSlots];
  logic       sh_fd     [NumSlots];
  logic       sh_lattn  [NumSlots];
  logic       sh_active [NumSlots];
  logic       sh_doneout[NumSlots];
  logic       sh_done   [NumSlots];
  logic [2:0] sh_cs     [NumSlots];
  logic [2:0] sh_attn   [NumSlots];
  logic [7:0] sh_olen   [NumSlots];
  logic [7:0] sh_ilen   [NumSlots];
  logic [7:0] sh_sent   [NumSlots];
  logic [7:0] sh_rcvd   [NumSlots];
  int unsigned sh_head;
  logic [7:0] sh_next_id;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_finishes = 0;
  int unsigned n_full = 0;
  int unsigned idle_cycles;
  int unsigned hold_cycles;
  logic        hold_start;
  logic        hold_taken;
  logic        hold_request;

  function automatic result_t blank_result();
    result_t r;
    r = '0;
    r.send_kind = SendNone;
    r.cs_action = CsNone;
    return r;
  endfunction

  // starts the first pending slot from the head when the bus is idle
  function automatic bit launch_next(inout result_t r);
    int unsigned i;
    if (sh_active[sh_head]) return 0;
    i = sh_head;
    do begin
      if (sh_id[i] != IdInvalid && !sh_active[i] && !sh_done[i]) begin
        sh_head = i;
        sh_active[i] = 1'b1;
        r.cs_action = CsAssert;
        r.chip_pin = sh_cs[i];
        r.bus_id = sh_id[i];
        if (sh_olen[i] > 0) begin
          sh_sent[i] = 8'd1;
          r.send_kind = SendByte;
          r.send_index = 8'd0;
        end else begin
          r.send_kind = SendDummy;
        end
        return 1;
      end
      i = (i + 1) % NumSlots;
    end while (i != sh_head);
    return 0;
  endfunction

  function automatic int find_slot(logic [7:0] id);
    for (int i = 0; i < NumSlots; i++) begin
      if (sh_id[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic sequence_request(request_t q);
    result_t r;
    result_t r2;
    int k;
    int unsigned h;
    logic attn;
    logic [7:0] bo;
    logic [7:0] bi;
    r = blank_result();
    case (q.action)
      ActSubmit: begin
        k = -1;
        h = sh_head;
        do begin
          if (sh_id[h] == IdInvalid) begin
            k = h;
            break;
          end
          h = (h + 1) % NumSlots;
        end while (h != sh_head);
        if (k < 0) begin
          r.status = 1'b1;
          n_full++;
        end else begin
          sh_id[k] = sh_next_id;
          r.reply_id = sh_next_id;
          sh_next_id = sh_next_id + 8'd1;
          if (sh_next_id == IdInvalid) sh_next_id = IdFirst;
          sh_fd[k] = q.fdx;
          sh_lattn[k] = 1'b0;
          sh_active[k] = 1'b0;
          sh_doneout[k] = 1'b0;
          sh_done[k] = 1'b0;
          sh_cs[k] = q.cs_pin;
          sh_attn[k] = q.fdx ? q.attn_pin : 3'd0;
          sh_olen[k] = q.tx_len;
          sh_ilen[k] = q.fdx ? 8'd0 : q.rx_len;
          sh_sent[k] = 8'd0;
          sh_rcvd[k] = 8'd0;
          void'(launch_next(r));
        end
      end
      ActByteDone: begin
        h = sh_head;
        if (sh_active[h]) begin
          bo = sh_sent[h];
          bi = sh_rcvd[h];
          attn = q.port_level[sh_attn[h]];
          r.bus_id = sh_id[h];
          if ((!sh_fd[h] && sh_doneout[h] && bi < sh_ilen[h]) ||
              (sh_fd[h] && (sh_lattn[h] || attn))) begin
            r.recv_valid = 1'b1;
            r.recv_index = bi;
            r.recv_byte = q.rx_byte;
            bi = bi + 8'd1;
          end
          sh_lattn[h] = attn;
          if (bo < sh_olen[h]) begin
            r.send_kind = SendByte;
            r.send_index = bo;
            bo = bo + 8'd1;
          end else if ((sh_fd[h] && attn) || (!sh_fd[h] && bi < sh_ilen[h])) begin
            r.send_kind = SendDummy;
            sh_doneout[h] = 1'b1;
          end else begin
            r.cs_action = CsRelease;
            r.chip_pin = sh_cs[h];
            sh_done[h] = 1'b1;
            sh_active[h] = 1'b0;
            n_finishes++;
          end
          sh_sent[h] = bo;
          sh_rcvd[h] = bi;
          if (r.cs_action == CsRelease) begin
            sh_head = (h + 1) % NumSlots;
            r2 = blank_result();
            if (launch_next(r2)) begin
              expected_results.push_back(r);
              r = r2;
            end
          end
        end
      end
      ActQuery: begin
        k = find_slot(q.txn_id);
        r.done_answer = (k >= 0) && sh_done[k];
      end
      default: begin
        k = find_slot(q.txn_id);
        if (k >= 0 && !sh_active[k]) sh_id[k] = IdInvalid;
        else r.status = 1'b1;
      end
    endcase
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [7:0] seen, logic [7:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", n_results, what, seen, want);
  endtask

  function automatic request_t random_request(action_e act);
    request_t q;
    q.action = act;
    q.fdx = 1'($urandom_range(0, 1));
    q.cs_pin = 3'($urandom_range(0, 7));
    q.attn_pin = 3'($urandom_range(0, 7));
    // mostly short transfers so transactions finish; a few long ones
    q.tx_len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    q.rx_len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    q.txn_id = 8'($urandom);
    q.rx_byte = 8'($urandom);
    q.port_level = 8'($urandom);
    return q;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: bursts of requests with random gaps; hold_request parks it.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_q <= '0;
      burst_left <= 0;
      gap_left <= 0;
      sh_head = 0;
      sh_next_id = IdFirst;
      for (int i = 0; i < NumSlots; i++) begin
        sh_id[i] = '0; sh_fd[i] = 0; sh_lattn[i] = 0; sh_active[i] = 0;
        sh_doneout[i] = 0; sh_done[i] = 0; sh_cs[i] = '0; sh_attn[i] = '0;
        sh_olen[i] = '0; sh_ilen[i] = '0; sh_sent[i] = '0; sh_rcvd[i] = '0;
      end
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sequence_request(req_q);
        n_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request
      end else if (hold_request || pending_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        req_q <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor plus receiver stall pattern; hold_start triggers one long stall.
  int unsigned stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 8'd0, 8'd0);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (got.status != e.status)
            report_mismatch("status", 8'(got.status), 8'(e.status));
          if (got.reply_id != e.reply_id) report_mismatch("reply_id", got.reply_id, e.reply_id);
          if (got.done_answer != e.done_answer)
            report_mismatch("done_answer", 8'(got.done_answer), 8'(e.done_answer));
          if (got.recv_valid != e.recv_valid)
            report_mismatch("recv_valid", 8'(got.recv_valid), 8'(e.recv_valid));
          if (got.recv_index != e.recv_index)
            report_mismatch("recv_index", got.recv_index, e.recv_index);
          if (got.recv_byte != e.recv_byte)
            report_mismatch("recv_byte", got.recv_byte, e.recv_byte);
          if (got.send_kind != e.send_kind)
            report_mismatch("send_kind", 8'(got.send_kind), 8'(e.send_kind));
          if (got.send_index != e.send_index)
            report_mismatch("send_index", got.send_index, e.send_index);
          if (got.bus_id != e.bus_id) report_mismatch("bus_id", got.bus_id, e.bus_id);
          if (got.cs_action != e.cs_action)
            report_mismatch("cs_action", 8'(got.cs_action), 8'(e.cs_action));
          if (got.chip_pin != e.chip_pin)
            report_mismatch("chip_pin", 8'(got.chip_pin), 8'(e.chip_pin));
          if (got.last != e.last) report_mismatch("last", 8'(got.last), 8'(e.last));
        end
        n_results++;
      end
      if (hold_start && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cycles <= HoldLen;
        out_stall_i <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        // rotate among no stall, light stall and heavy stall
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no progress for %0d cycles", idle_cycles);
        $display("spi_transaction_queue_sequencer_top test failed");
        $finish;
      end
    end
  end

  initial begin
    request_t q;
    hold_start = 1'b0;
    hold_request = 1'b0;

    // Directed: idle byte_done, id zero lookups, extremes, fill and refused clear.
    q = random_request(ActByteDone);
    pending_reqs.push_back(q);
    q.action = ActQuery; q.txn_id = 8'd0; pending_reqs.push_back(q);
    q.action = ActClear; q.txn_id = 8'd0; pending_reqs.push_back(q);
    q = '0; q.action = ActSubmit; q.fdx = 1'b1; q.cs_pin = 3'd7; q.attn_pin = 3'd7;
    q.tx_len = 8'd0; q.rx_len = 8'hff;
    pending_reqs.push_back(q);
    q.action = ActClear; q.txn_id = 8'd1; pending_reqs.push_back(q);  // active: refused
    q.action = ActByteDone; q.port_level = 8'hff; q.rx_byte = 8'hff; pending_reqs.push_back(q);
    q.port_level = 8'h00; q.rx_byte = 8'h00; pending_reqs.push_back(q);
    q.port_level = 8'h00; pending_reqs.push_back(q);
    q.action = ActQuery; q.txn_id = 8'd1; pending_reqs.push_back(q);
    q.action = ActQuery; q.txn_id = 8'hff; pending_reqs.push_back(q);
    for (int i = 0; i < 10; i++) begin
      q = random_request(ActSubmit);
      q.fdx = 1'b0; q.tx_len = 8'd1; q.rx_len = (i == 0) ? 8'd0 : 8'd2;
      pending_reqs.push_back(q);  // the last ones hit a full queue
    end
    q.action = ActClear; q.txn_id = 8'd4; pending_reqs.push_back(q);  // pending: allowed
    for (int i = 0; i < 6; i++) begin
      q = random_request(ActByteDone);
      pending_reqs.push_back(q);
    end

    wait (pending_reqs.size() == 0 && !in_valid_i);
    // sender pauses until everything has come out
    hold_request = 1'b1;
    wait (expected_results.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    hold_request = 1'b0;

    // Random: byte_done heavy so transactions run to completion; ids wrap past 255.
    for (int n = 0; n < 1250; n++) begin
      int unsigned pick;
      action_e act;
      pick = $urandom_range(0, 99);
      if (pick < 25) act = ActSubmit;
      else if (pick < 80) act = ActByteDone;
      else if (pick < 90) act = ActQuery;
      else act = ActClear;
      q = random_request(act);
      // point lookups at live ids most of the time
      if (act inside {ActQuery, ActClear} && $urandom_range(0, 3) != 0)
        q.txn_id = sh_next_id - 8'($urandom_range(1, 10));
      pending_reqs.push_back(q);
      if (n == 600) begin
        wait (pending_reqs.size() < 5);
        // long receiver hold-off while the sender keeps offering requests
        @(posedge clk_i);
        hold_start = 1'b1;
      end
    end

    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests, %0d results, %0d finished transfers, %0d queue-full submits",
             n_accepted, n_results, n_finishes, n_full);
    if (errors == 0) begin
      $display("spi_transaction_queue_sequencer_top test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("spi_transaction_queue_sequencer_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/stqs_pkg.sv
hw/rtl/stqs_out_reg.sv
hw/rtl/spi_transaction_queue_sequencer_top.sv
bench/spi_transaction_queue_sequencer_top_test.sv
